@@ hw/rtl/rgb_to_hsl_pixel_defines.svh @@
// Assertion macros used by the rgb_to_hsl_pixel checker.
`ifndef RGB_TO_HSL_PIXEL_DEFINES_SVH
`define RGB_TO_HSL_PIXEL_DEFINES_SVH

// Clocked assertion, ignored while reset is asserted.
`define RTH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RTH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hw/rtl/rth_pkg.sv @@
// Shared types and constants for the RGB to HSL pixel converter.
package rth_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned DIV_QW   = 7;
    localparam int unsigned HDVD_W   = 14;
    localparam int unsigned SDVD_W   = 15;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 24;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } max_sel_t;

    typedef struct packed {
        logic [PCT_W-1:0] light;
        max_sel_t         sel;
        logic             neg;
    } hue_side_t;

    typedef struct packed {
        logic grey;
    } sat_side_t;

endpackage

@@ hw/rtl/rth_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband bus.
module rth_div_pipe #(
    parameter int unsigned DW = 14,
    parameter int unsigned VW = 8,
    parameter int unsigned QW = 7,
    parameter int unsigned SW = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] quotient,
    output logic [DW-1:0] remainder,
    output logic [SW-1:0] side_out
);

    localparam int unsigned CW = DW + VW;

    logic [DW-1:0] rem_reg  [QW];
    logic [VW-1:0] dvs_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int unsigned SH = QW - 1 - k;
        logic [DW-1:0] rem_prev;
        logic [VW-1:0] dvs_prev;
        logic [QW-1:0] quo_prev;
        logic [SW-1:0] side_prev;
        logic [CW-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_prev  = dividend;
            assign dvs_prev  = divisor;
            assign quo_prev  = '0;
            assign side_prev = side_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial = CW'(dvs_prev) << SH;

        always_comb begin
            rem_next[k] = rem_prev;
            quo_next[k] = quo_prev;
            if (CW'(rem_prev) >= trial) begin
                rem_next[k]     = DW'(CW'(rem_prev) - trial);
                quo_next[k][SH] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_prev;
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= side_prev;
            end
        end
    end

    assign quotient  = quo_reg[QW-1];
    assign remainder = rem_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

@@ hw/rtl/rgb_to_hsl_pixel.sv @@
// Pipeline: 2 front stages, 7 divider stages and an output register from input to result.
// One pixel per cycle unless output stalls; both dividers pipelined, one quotient bit a stage.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears every valid bit; data registers are not reset.
module rgb_to_hsl_pixel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rth_pkg::S_DATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rth_pkg::M_DATA_W-1:0]  m_tdata    // hue, saturation, lightness, pad
);

    localparam int unsigned CW  = rth_pkg::CHAN_W;
    localparam int unsigned PW  = rth_pkg::PCT_W;
    localparam int unsigned HW  = rth_pkg::HUE_W;
    localparam int unsigned QW  = rth_pkg::DIV_QW;
    localparam int unsigned HDW = rth_pkg::HDVD_W;
    localparam int unsigned SDW = rth_pkg::SDVD_W;
    localparam int unsigned HSW = $bits(rth_pkg::hue_side_t);
    localparam int unsigned SSW = $bits(rth_pkg::sat_side_t);

    logic                         m_tvalid_reg;
    logic [rth_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage A: max, min, difference ----------------
    logic [CW-1:0] red, green, blue;
    assign red   = s_tdata[CW-1:0];
    assign green = s_tdata[2*CW-1:CW];
    assign blue  = s_tdata[3*CW-1:2*CW];

    rth_pkg::max_sel_t sel_a;
    logic [CW-1:0]     mx_a, mn_a;
    logic [CW:0]       diff_a;

    always_comb begin
        if (blue >= red && blue >= green) begin
            sel_a  = rth_pkg::SEL_BLUE;
            mx_a   = blue;
            diff_a = {1'b0, red} - {1'b0, green};
        end else if (green >= red) begin
            sel_a  = rth_pkg::SEL_GREEN;
            mx_a   = green;
            diff_a = {1'b0, blue} - {1'b0, red};
        end else begin
            sel_a  = rth_pkg::SEL_RED;
            mx_a   = red;
            diff_a = {1'b0, green} - {1'b0, blue};
        end
        mn_a = red;
        if (green < mn_a) mn_a = green;
        if (blue < mn_a) mn_a = blue;
    end

    logic              a_valid_reg;
    logic [CW:0]       a_sum_reg;
    logic [CW-1:0]     a_d_reg;
    logic [CW-1:0]     a_abs_reg;
    logic              a_neg_reg;
    rth_pkg::max_sel_t a_sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sum_reg <= {1'b0, mx_a} + {1'b0, mn_a};
            a_d_reg   <= mx_a - mn_a;
            a_neg_reg <= diff_a[CW];
            a_abs_reg <= diff_a[CW] ? CW'(-diff_a) : diff_a[CW-1:0];
            a_sel_reg <= sel_a;
        end
    end

    // ---------------- stage B: dividends, divisors, lightness estimate ----------------
    logic [SDW-1:0] lx_b;
    logic [22:0]    lprod_b;
    assign lx_b    = SDW'(a_sum_reg) * SDW'(50);
    assign lprod_b = 23'(lx_b) + (23'(lx_b) << 8);

    logic              b_valid_reg;
    logic [HDW-1:0]    b_hdvd_reg;
    logic [CW-1:0]     b_hdvs_reg;
    logic [SDW-1:0]    b_sdvd_reg;
    logic [CW-1:0]     b_sdvs_reg;
    logic [SDW-1:0]    b_lx_reg;
    logic [PW-1:0]     b_lq_reg;
    logic              b_neg_reg;
    logic              b_grey_reg;
    rth_pkg::max_sel_t b_sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_hdvd_reg <= HDW'(a_abs_reg) * HDW'(60);
            b_hdvs_reg <= a_d_reg;
            b_sdvd_reg <= SDW'(a_d_reg) * SDW'(100);
            b_sdvs_reg <= (a_sum_reg < (CW+1)'(255)) ? a_sum_reg[CW-1:0]
                                                     : CW'((CW+1)'(510) - a_sum_reg);
            b_lx_reg   <= lx_b;
            b_lq_reg   <= lprod_b[22:16];
            b_neg_reg  <= a_neg_reg;
            b_grey_reg <= (a_d_reg == '0);
            b_sel_reg  <= a_sel_reg;
        end
    end

    // lightness correction: estimate is exact or one low
    logic [SDW-1:0] lrem_c;
    logic [PW-1:0]  light_c;
    assign lrem_c  = b_lx_reg - ((SDW'(b_lq_reg) << 8) - SDW'(b_lq_reg));
    assign light_c = (lrem_c >= SDW'(255)) ? b_lq_reg + PW'(1) : b_lq_reg;

    rth_pkg::hue_side_t hside_in, hside_out;
    rth_pkg::sat_side_t sside_in, sside_out;

    always_comb begin
        hside_in.light = light_c;
        hside_in.sel   = b_sel_reg;
        hside_in.neg   = b_neg_reg;
        sside_in.grey  = b_grey_reg;
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0]  hq, sq;
    logic [HDW-1:0] hrem;
    logic [SDW-1:0] srem;

    rth_div_pipe #(.DW(HDW), .VW(CW), .QW(QW), .SW(HSW)) u_hue_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (b_hdvd_reg),
        .divisor   (b_hdvs_reg),
        .side_in   (hside_in),
        .quotient  (hq),
        .remainder (hrem),
        .side_out  (hside_out)
    );

    rth_div_pipe #(.DW(SDW), .VW(CW), .QW(QW), .SW(SSW)) u_sat_div (
        .aclk      (aclk),
        .en        (en),
        .dividend  (b_sdvd_reg),
        .divisor   (b_sdvs_reg),
        .side_in   (sside_in),
        .quotient  (sq),
        .remainder (srem),
        .side_out  (sside_out)
    );

    logic [QW-1:0] dv_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg <= '0;
        end else if (en) begin
            dv_valid_reg <= {dv_valid_reg[QW-2:0], b_valid_reg};
        end
    end

    // ---------------- output stage ----------------
    logic [HW-1:0] q9, adj9, hue_next;
    logic [PW-1:0] sat_next;

    assign q9   = HW'(hq);
    assign adj9 = q9 + HW'(hrem != '0);

    always_comb begin
        unique case (hside_out.sel)
            rth_pkg::SEL_BLUE:  hue_next = hside_out.neg ? HW'(240) - adj9 : HW'(240) + q9;
            rth_pkg::SEL_GREEN: hue_next = hside_out.neg ? HW'(120) - adj9 : HW'(120) + q9;
            default: begin
                if (hside_out.neg && hq != '0) hue_next = HW'(360) - q9;
                else                           hue_next = q9;
            end
        endcase
        sat_next = sq;
        if (sside_out.grey) begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {1'b0, hside_out.light, sat_next, hue_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hw/rtl/rgb_to_hsl_pixel_checker.sv @@
// Port-level checker for rgb_to_hsl_pixel and its bind.
`include "rgb_to_hsl_pixel_defines.svh"

module rgb_to_hsl_pixel_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rth_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rth_pkg::M_DATA_W-1:0]  m_tdata
);

    `RTH_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "output valid after reset")
    `RTH_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled transfer changed")
    `RTH_ASSERT(a_ranges, m_tvalid |-> m_tdata[8:0] < 9'd360 && m_tdata[15:9] <= 7'd100 && m_tdata[22:16] <= 7'd100, "result out of range")
    `RTH_ASSERT(a_no_block, m_tready |-> s_tready, "input blocked while output drains")

endmodule

bind rgb_to_hsl_pixel rgb_to_hsl_pixel_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/rgb_to_hsl_pixel_tb.sv @@
// Self-checking testbench for the rgb_to_hsl_pixel stream converter.
`timescale 1ns / 100ps

module rgb_to_hsl_pixel_tb;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned RANDOM_PIXELS = 1330;

    typedef struct {
        logic [rth_pkg::HUE_W-1:0] hue;
        logic [rth_pkg::PCT_W-1:0] sat;
        logic [rth_pkg::PCT_W-1:0] light;
    } hsl_t;

    class hsl_scoreboard;
        hsl_t        expected_hsl[$];
        int unsigned errors;
        int unsigned pixels_in;
        int unsigned results_checked;

        function new();
            errors          = 0;
            pixels_in       = 0;
            results_checked = 0;
        endfunction

        // Integer HSL of one pixel; int division truncates toward zero.
        function hsl_t convert_pixel(logic [rth_pkg::CHAN_W-1:0] red,
                                     logic [rth_pkg::CHAN_W-1:0] green,
                                     logic [rth_pkg::CHAN_W-1:0] blue);
            int                r, g, b, hi, lo, sum, span, num, h, s, l;
            rth_pkg::max_sel_t sel;
            hsl_t              res;
            r = red;
            g = green;
            b = blue;
            hi = r;
            lo = r;
            sel = rth_pkg::SEL_RED;
            if (g >= hi) begin
                hi = g;
                sel = rth_pkg::SEL_GREEN;
            end
            if (b >= hi) begin
                hi = b;
                sel = rth_pkg::SEL_BLUE;
            end
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            sum  = hi + lo;
            span = hi - lo;
            l = (50 * sum) / 255;
            if (span == 0) begin
                s = 0;
                h = 0;
            end else begin
                s = (sum < 255) ? (100 * span) / sum : (100 * span) / (510 - sum);
                case (sel)
                    rth_pkg::SEL_BLUE:  num = 60 * (r - g) + 240 * span;
                    rth_pkg::SEL_GREEN: num = 60 * (b - r) + 120 * span;
                    default:            num = 60 * (g - b);
                endcase
                h = num / span;
                if (h < 0) h += 360;
            end
            res.hue   = h[rth_pkg::HUE_W-1:0];
            res.sat   = s[rth_pkg::PCT_W-1:0];
            res.light = l[rth_pkg::PCT_W-1:0];
            return res;
        endfunction

        function void note_pixel(logic [rth_pkg::S_DATA_W-1:0] data);
            expected_hsl.push_back(convert_pixel(data[7:0], data[15:8], data[23:16]));
            pixels_in++;
        endfunction

        function void check_result(logic [rth_pkg::M_DATA_W-1:0] data);
            hsl_t exp_hsl;
            if (expected_hsl.size() == 0) begin
                $error("result transfer with no pixel outstanding: 0x%06h", data);
                errors++;
                return;
            end
            exp_hsl = expected_hsl.pop_front();
            results_checked++;
            if (data[8:0] !== exp_hsl.hue) begin
                $error("hue: expected %0d, got %0d", exp_hsl.hue, data[8:0]);
                errors++;
            end
            if (data[15:9] !== exp_hsl.sat) begin
                $error("saturation: expected %0d, got %0d", exp_hsl.sat, data[15:9]);
                errors++;
            end
            if (data[22:16] !== exp_hsl.light) begin
                $error("lightness: expected %0d, got %0d", exp_hsl.light, data[22:16]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_hsl.size();
        endfunction
    endclass

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [rth_pkg::S_DATA_W-1:0] s_tdata  = '0;    // red, green, blue
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [rth_pkg::M_DATA_W-1:0] m_tdata;          // hue, saturation, lightness, pad

    hsl_scoreboard sb;
    bit            calm = 1'b0;            // no gaps on either side while set
    int unsigned   idle_cycles = 0;
    int unsigned   ready_hold = 0;

    rgb_to_hsl_pixel u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (calm || p < 70) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // channel value at or next to 0 or 255
    function automatic logic [rth_pkg::CHAN_W-1:0] rail_value();
        if ($urandom_range(1)) return rth_pkg::CHAN_W'(8'hFF - $urandom_range(1));
        return rth_pkg::CHAN_W'($urandom_range(1));
    endfunction

    task automatic send_pixel(logic [rth_pkg::CHAN_W-1:0] red,
                              logic [rth_pkg::CHAN_W-1:0] green,
                              logic [rth_pkg::CHAN_W-1:0] blue);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel({blue, green, red});
    endtask

    task automatic send_random_pixel();
        logic [rth_pkg::CHAN_W-1:0] r, g, b, v;
        int unsigned                kind;
        r = rth_pkg::CHAN_W'($urandom);
        g = rth_pkg::CHAN_W'($urandom);
        b = rth_pkg::CHAN_W'($urandom);
        kind = $urandom_range(99);
        if (kind < 10) begin
            g = r;
            b = r;
        end else if (kind < 25) begin
            case ($urandom_range(2))
                0:       g = r;
                1:       b = g;
                default: b = r;
            endcase
        end else if (kind < 35) begin
            v = rth_pkg::CHAN_W'($urandom);
            r = ($urandom_range(3) == 0) ? v : rail_value();
            g = ($urandom_range(3) == 0) ? v : rail_value();
            b = ($urandom_range(3) == 0) ? v : rail_value();
        end else if (kind < 45) begin
            // red on top, green and blue close: hue near zero or just below 360
            r = rth_pkg::CHAN_W'($urandom_range(2, 255));
            g = rth_pkg::CHAN_W'($urandom_range(0, r - 2));
            b = rth_pkg::CHAN_W'(g + $urandom_range(0, 2));
            if ($urandom_range(1)) {g, b} = {b, g};
        end
        send_pixel(r, g, b);
    endtask

    // Result side back-pressure.
    always @(posedge aclk) begin : ready_gen
        int unsigned gap;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready) begin
            gap = gap_len();
            if (gap > 0) begin
                m_tready   <= 1'b0;
                ready_hold <= gap - 1;
            end else begin
                ready_hold <= $urandom_range(0, 15);
            end
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners: black, white, grey, primaries, secondaries (ties), wrap and boundary cases
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd100, 8'd100, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd5);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd200, 8'd55,  8'd100);
        send_pixel(8'd200, 8'd54,  8'd100);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd10,  8'd200, 8'd200);
        send_pixel(8'd128, 8'd64,  8'd64);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd255, 8'd254);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            calm = (i >= 500 && i < 700);
            send_random_pixel();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("pixels sent: %0d, results checked: %0d", sb.pixels_in, sb.results_checked);
        $display("covered grey, tied maxima, hue wrap near 0/360, lightness 50 boundary, stalls");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
